[rtl/core/bdq_pkg.sv]
// Shared types, codes and defaults for the bounded deque.
package bdq_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int VALUE_W       = 32;

	typedef logic [2:0] op_t;
	typedef logic [1:0] status_t;

	localparam op_t OP_PUSH_FRONT = 3'd0;
	localparam op_t OP_PUSH_BACK  = 3'd1;
	localparam op_t OP_POP_FRONT  = 3'd2;
	localparam op_t OP_POP_BACK   = 3'd3;
	localparam op_t OP_LIST_FWD   = 3'd4;
	localparam op_t OP_LIST_REV   = 3'd5;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    push_front;
		logic    push_back;
		logic    pop_front;
		logic    pop_back;
		logic    list_start;
		logic    list_rev;
		logic    list_step;
		logic    out_imm;
		status_t imm_status;
		logic    out_mem;
		logic    out_last;
	} bdq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic list_last;
		logic out_free;
	} bdq_sts_t;

endpackage

[rtl/core/bdq_if.sv]
// Operation and result channel interfaces of the bounded deque.
interface bdq_in_if;
	logic                     valid;
	logic                     ready;
	bdq_pkg::op_t             op;
	logic signed [31:0]       value_in;

	modport source (output valid, output op, output value_in, input ready);
	modport sink   (input valid, input op, input value_in, output ready);
endinterface

interface bdq_out_if;
	logic                     valid;
	logic                     ready;
	logic signed [31:0]       value_out;
	bdq_pkg::status_t         status;
	logic                     last_of_run;

	modport source (output valid, output value_out, output status, output last_of_run,
		input ready);
	modport sink   (input valid, input value_out, input status, input last_of_run,
		output ready);
endinterface

[rtl/core/bdq_ctrl.sv]
// Controller state machine of the bounded deque.
module bdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  bdq_pkg::op_t      op,
	output logic              in_ready,
	input  bdq_pkg::bdq_sts_t sts,
	output bdq_pkg::bdq_cmd_t cmd
);
	import bdq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_LIST = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_ready = (state_q == S_IDLE) && sts.out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							cmd.out_imm = 1'b1;
							if (sts.full) begin
								cmd.imm_status = ST_FULL;
							end else begin
								cmd.imm_status = ST_OK;
								cmd.push_front = (op == OP_PUSH_FRONT);
								cmd.push_back  = (op == OP_PUSH_BACK);
							end
						end
						OP_POP_FRONT, OP_POP_BACK: begin
							if (sts.empty) begin
								cmd.out_imm    = 1'b1;
								cmd.imm_status = ST_EMPTY;
							end else begin
								cmd.pop_front = (op == OP_POP_FRONT);
								cmd.pop_back  = (op == OP_POP_BACK);
								state_d       = S_READ;
							end
						end
						OP_LIST_FWD, OP_LIST_REV: begin
							if (sts.empty) begin
								cmd.out_imm    = 1'b1;
								cmd.imm_status = ST_EMPTY;
							end else begin
								cmd.list_start = 1'b1;
								cmd.list_rev   = (op == OP_LIST_REV);
								state_d        = S_LIST;
							end
						end
						default: begin
							// unused codes: drop the item silently
						end
					endcase
				end
			end
			S_READ: begin
				if (sts.out_free) begin
					cmd.out_mem  = 1'b1;
					cmd.out_last = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_LIST: begin
				if (sts.out_free) begin
					cmd.out_mem  = 1'b1;
					cmd.out_last = sts.list_last;
					if (sts.list_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.list_step = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/bdq_dp.sv]
// Datapath of the bounded deque: ring store, pointers, walk counter, result register.
module bdq_dp #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bdq_pkg::bdq_cmd_t        cmd,
	input  logic signed [31:0]       value_in,
	input  logic                     out_ready,
	output bdq_pkg::bdq_sts_t        sts,
	output logic                     out_valid,
	output logic signed [31:0]       value_out,
	output bdq_pkg::status_t         status,
	output logic                     last_of_run
);
	import bdq_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [VALUE_W-1:0] mem [DEPTH];

	logic [PW-1:0]      front_q;
	logic [CW-1:0]      count_q;
	logic [PW-1:0]      k_q;
	logic               rev_q;
	logic [VALUE_W-1:0] rd_q;

	logic               out_valid_q;
	logic [VALUE_W-1:0] value_q;
	status_t            status_q;
	logic               last_q;

	logic [PW-1:0]      front_prev;
	logic [PW-1:0]      front_next;
	logic [PW-1:0]      back_off;
	logic [CW-1:0]      k_inc;
	logic [PW-1:0]      step_off;
	logic               we;
	logic [PW-1:0]      waddr;
	logic               re;
	logic [PW-1:0]      raddr;

	// Ring position at offset off from base; off stays below DEPTH.
	function automatic logic [PW-1:0] ring_at(input logic [PW-1:0] base,
		input logic [PW-1:0] off);
		logic [PW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (PW+1)'(DEPTH)) begin
			s = s - (PW+1)'(DEPTH);
		end
		return s[PW-1:0];
	endfunction

	assign front_prev = (front_q == '0) ? PW'(DEPTH - 1) : front_q - PW'(1);
	assign front_next = (front_q == PW'(DEPTH - 1)) ? '0 : front_q + PW'(1);
	assign back_off   = PW'(count_q - CW'(1));
	assign k_inc      = CW'(k_q) + CW'(1);
	// next entry of a walk: k+1 forward, count-2-k backward
	assign step_off   = rev_q ? PW'(count_q - CW'(1) - k_inc) : PW'(k_inc);

	assign we    = cmd.push_front || cmd.push_back;
	assign waddr = cmd.push_front ? front_prev : ring_at(front_q, PW'(count_q));

	assign re = cmd.pop_front || cmd.pop_back || cmd.list_start || cmd.list_step;
	always_comb begin
		priority if (cmd.pop_front) begin
			raddr = front_q;
		end else if (cmd.pop_back) begin
			raddr = ring_at(front_q, back_off);
		end else if (cmd.list_start) begin
			raddr = cmd.list_rev ? ring_at(front_q, back_off) : front_q;
		end else begin
			raddr = ring_at(front_q, step_off);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= value_in;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			k_q     <= '0;
			rev_q   <= 1'b0;
		end else begin
			if (cmd.push_front) begin
				front_q <= front_prev;
			end else if (cmd.pop_front) begin
				front_q <= front_next;
			end
			if (we) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop_front || cmd.pop_back) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.list_start) begin
				k_q   <= '0;
				rev_q <= cmd.list_rev;
			end else if (cmd.list_step) begin
				k_q <= PW'(k_inc);
			end
		end
	end

	// Result register: hold until taken, reload from command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_imm || cmd.out_mem) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_imm) begin
			value_q  <= '0;
			status_q <= cmd.imm_status;
			last_q   <= 1'b1;
		end else if (cmd.out_mem) begin
			value_q  <= rd_q;
			status_q <= ST_OK;
			last_q   <= cmd.out_last;
		end
	end

	assign sts.full      = (count_q == CW'(DEPTH));
	assign sts.empty     = (count_q == '0);
	assign sts.list_last = (k_inc == count_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign value_out   = value_q;
	assign status      = status_q;
	assign last_of_run = last_q;

endmodule

[rtl/core/bounded_deque_with_traversal.sv]
// Top level of the bounded double-ended queue with front-to-back and back-to-front listing.
// A push, a rejected push and any operation on an empty queue give one result without a
// store read. A pop needs a store read: the entry store has a single registered read port,
// so the removed value is read into the read register on acceptance and then moved into the
// result register. A listing of N entries makes one store read per entry, with the results
// streaming one per cycle while the result side keeps taking them. Op codes six and seven
// are consumed without a result. The store is not cleared after reset; only held entries
// are ever read. A new item is taken no earlier than the cycle in which the last result
// of the previous one is taken; a stalled result register holds the input back.
module bounded_deque_with_traversal #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	bdq_in_if.sink    in_ch,
	bdq_out_if.source out_ch
);
	import bdq_pkg::*;

	bdq_cmd_t cmd;
	bdq_sts_t sts;

	bdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.op       (in_ch.op),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bdq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.value_in    (in_ch.value_in),
		.out_ready   (out_ch.ready),
		.sts         (sts),
		.out_valid   (out_ch.valid),
		.value_out   (out_ch.value_out),
		.status      (out_ch.status),
		.last_of_run (out_ch.last_of_run)
	);

	// never take an item while a result is stuck in the output register
	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> (!out_ch.valid || out_ch.ready))
		else $error("item taken with result register blocked");

	a_push_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready &&
		 (in_ch.op == OP_PUSH_FRONT || in_ch.op == OP_PUSH_BACK))
		|=> (out_ch.valid && out_ch.last_of_run && out_ch.value_out == '0))
		else $error("push did not give a single result");

	a_busy_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && !sts.empty &&
		 (in_ch.op == OP_POP_FRONT || in_ch.op == OP_POP_BACK ||
		  in_ch.op == OP_LIST_FWD || in_ch.op == OP_LIST_REV))
		|=> !in_ch.ready)
		else $error("new item taken while a store read is outstanding");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status != ST_OK)
		|-> (out_ch.value_out == '0 && out_ch.last_of_run))
		else $error("failed result carries data or is not last");

endmodule

[tb/tb.sv]
// Self-checking testbench for the bounded deque: a directed table, then randomised traffic.
module tb;
	import bdq_pkg::*;

	localparam int DEPTH          = DEPTH_DEFAULT;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int ITEMS_PER_PHASE = 96;
	localparam int NUM_PHASES     = 4;

	typedef struct packed {
		logic signed [31:0] value;
		status_t            status;
		logic               last;
	} result_t;

	// One row of the directed table; typed rows carry their result written out by hand.
	typedef struct {
		op_t                op;
		logic signed [31:0] value;
		bit                 typed;
		bit                 gives;
		result_t            res;
	} stim_row_t;

	localparam result_t R_OK    = '{32'sd0, ST_OK, 1'b1};
	localparam result_t R_EMPTY = '{32'sd0, ST_EMPTY, 1'b1};
	localparam result_t R_FULL  = '{32'sd0, ST_FULL, 1'b1};
	localparam result_t R_NONE  = '0;

	localparam op_t OP_UNUSED_6 = 3'd6;
	localparam op_t OP_UNUSED_7 = 3'd7;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

	localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 87, 0, 16};
	localparam int RECV_STALL_PCT[NUM_PHASES] = '{0, 0, 87, 16};

	stim_row_t directed_rows [26] = '{
		'{OP_POP_FRONT,  32'sd0,           1, 1, R_EMPTY},
		'{OP_POP_BACK,   32'sd0,           1, 1, R_EMPTY},
		'{OP_LIST_FWD,   32'sd0,           1, 1, R_EMPTY},
		'{OP_LIST_REV,   32'sd0,           1, 1, R_EMPTY},
		'{OP_UNUSED_6,   32'sh7fffffff,    1, 0, R_NONE},
		'{OP_UNUSED_7,   32'sh80000000,    1, 0, R_NONE},
		'{OP_PUSH_FRONT, 32'sh80000000,    1, 1, R_OK},
		'{OP_PUSH_BACK,  32'sh7fffffff,    1, 1, R_OK},
		'{OP_PUSH_FRONT, 32'shffffffff,    1, 1, R_OK},
		'{OP_PUSH_BACK,  32'sh00000000,    1, 1, R_OK},
		'{OP_PUSH_FRONT, 32'sh55555555,    1, 1, R_OK},
		'{OP_PUSH_BACK,  32'shaaaaaaaa,    1, 1, R_OK},
		'{OP_PUSH_FRONT, 32'sh00000001,    1, 1, R_OK},
		'{OP_PUSH_BACK,  32'shfffffffe,    1, 1, R_OK},
		'{OP_PUSH_FRONT, 32'sh12345678,    1, 1, R_OK},
		'{OP_PUSH_BACK,  32'shedcba987,    1, 1, R_OK},
		'{OP_PUSH_FRONT, 32'sh40000000,    1, 1, R_OK},
		'{OP_PUSH_BACK,  32'shbfffffff,    1, 1, R_OK},
		'{OP_PUSH_FRONT, 32'sh00010000,    1, 1, R_OK},
		'{OP_PUSH_BACK,  32'shfffeffff,    1, 1, R_OK},
		'{OP_PUSH_FRONT, 32'sh7ffffffe,    1, 1, R_OK},
		'{OP_PUSH_BACK,  32'sh80000001,    1, 1, R_OK},
		'{OP_PUSH_FRONT, 32'sh0badf00d,    1, 1, R_FULL},
		'{OP_PUSH_BACK,  32'shdeadbeef,    1, 1, R_FULL},
		'{OP_LIST_FWD,   32'sh0,           0, 0, R_NONE},
		'{OP_LIST_REV,   32'sh0,           0, 0, R_NONE}
	};

	logic clk;
	logic arst_n;

	bdq_in_if  in_ch();
	bdq_out_if out_ch();

	bounded_deque_with_traversal #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// Predicted deque contents.
	logic signed [31:0] ring [DEPTH];
	int unsigned        head;
	int unsigned        fill;

	result_t pending_results[$];
	result_t step_results[$];

	int errors;
	int quiet_cycles;
	int send_idle_pct;
	int recv_stall_pct;

	bit      cur_typed;
	bit      cur_gives;
	result_t cur_res;

	function automatic result_t make_result(logic signed [31:0] v, status_t st, logic last);
		result_t r;
		r.value  = v;
		r.status = st;
		r.last   = last;
		return r;
	endfunction

	// Apply one operation to the predicted deque and collect the results it causes.
	function automatic void deque_step(op_t op, logic signed [31:0] v);
		int unsigned idx;
		int unsigned off;
		step_results.delete();
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (fill >= DEPTH) begin
					step_results.push_back(make_result(32'sd0, ST_FULL, 1'b1));
				end else begin
					if (op == OP_PUSH_FRONT) begin
						head = (head == 0) ? DEPTH - 1 : head - 1;
						ring[head] = v;
					end else begin
						ring[(head + fill) % DEPTH] = v;
					end
					fill++;
					step_results.push_back(make_result(32'sd0, ST_OK, 1'b1));
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (fill == 0) begin
					step_results.push_back(make_result(32'sd0, ST_EMPTY, 1'b1));
				end else begin
					if (op == OP_POP_FRONT) begin
						idx  = head;
						head = (head + 1) % DEPTH;
					end else begin
						idx = (head + fill - 1) % DEPTH;
					end
					fill--;
					step_results.push_back(make_result(ring[idx], ST_OK, 1'b1));
				end
			end
			OP_LIST_FWD, OP_LIST_REV: begin
				if (fill == 0) begin
					step_results.push_back(make_result(32'sd0, ST_EMPTY, 1'b1));
				end else begin
					for (int unsigned k = 0; k < fill; k++) begin
						off = (op == OP_LIST_FWD) ? k : fill - 1 - k;
						step_results.push_back(make_result(ring[(head + off) % DEPTH], ST_OK,
							k + 1 == fill));
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(7))
			0: return 32'sh80000000;
			1: return 32'sh7fffffff;
			2: return 32'sh0;
			3: return 32'shffffffff;
			default: return $urandom();
		endcase
	endfunction

	function automatic op_t pick_op(traffic_mode_t mode);
		int r;
		int push_pct;
		r = $urandom_range(99);
		if (r < 3)
			return $urandom_range(1) ? OP_UNUSED_7 : OP_UNUSED_6;
		if (r < 13)
			return $urandom_range(1) ? OP_LIST_REV : OP_LIST_FWD;
		push_pct = (mode == MODE_FILL) ? 83 : (mode == MODE_DRAIN) ? 17 : 50;
		if ($urandom_range(99) < push_pct)
			return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
	endfunction

	// Call at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_op(op_t op, logic signed [31:0] v, bit typed, bit gives, result_t res);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cur_typed = typed;
		cur_gives = gives;
		cur_res   = res;
		in_ch.valid    <= 1'b1;
		in_ch.op       <= op;
		in_ch.value_in <= v;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Hold the sender until every expected result has arrived.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk)
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	// Predict on each accepted operation, check each accepted result.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		bit      moved;
		moved = 1'b0;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			moved = 1'b1;
			deque_step(in_ch.op, in_ch.value_in);
			if (cur_typed) begin
				if (cur_gives)
					pending_results.push_back(cur_res);
			end else begin
				foreach (step_results[i])
					pending_results.push_back(step_results[i]);
			end
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			moved = 1'b1;
			got = make_result(out_ch.value_out, out_ch.status, out_ch.last_of_run);
			if (pending_results.size() == 0) begin
				$error("unexpected result: value_out %0d status %0d last_of_run %0b",
					got.value, got.status, got.last);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.value !== want.value) begin
					$error("value_out: expected %0d, got %0d", want.value, got.value);
					errors++;
				end
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					errors++;
				end
				if (got.last !== want.last) begin
					$error("last_of_run: expected %0b, got %0b", want.last, got.last);
					errors++;
				end
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		traffic_mode_t      mode;
		op_t                op;
		int                 counted;
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.op        = OP_PUSH_FRONT;
		in_ch.value_in  = '0;
		out_ch.ready    = 1'b0;
		head            = 0;
		fill            = 0;
		errors          = 0;
		quiet_cycles    = 0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		cur_typed       = 1'b0;
		cur_gives       = 1'b0;
		cur_res         = R_NONE;
		mode            = MODE_FILL;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_op(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
				directed_rows[i].gives, directed_rows[i].res);
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			send_idle_pct  = SEND_IDLE_PCT[p];
			recv_stall_pct = RECV_STALL_PCT[p];
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				// Swing between filling and draining so the full and empty edges are hit often.
				if (mode == MODE_FILL && fill == DEPTH && $urandom_range(3) == 0)
					mode = MODE_DRAIN;
				else if (mode == MODE_DRAIN && fill == 0 && $urandom_range(3) == 0)
					mode = MODE_FILL;
				else if ($urandom_range(23) == 0)
					mode = traffic_mode_t'($urandom_range(2));
				op = pick_op(mode);
				send_op(op, pick_value(), 1'b0, 1'b0, R_NONE);
				if (op <= OP_LIST_REV)
					counted++;
			end
			wait_drained();
		end

		repeat (DEPTH + 4) @(negedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
